FILE: src/mfb_pkg.sv
// mfb_pkg: shared constants, types and the 6x8 font table for the
// monochrome framebuffer plotter. No dependencies.

package mfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGES         = SCREEN_HEIGHT / 8;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DATA_W      = 8;

  localparam int COORD_W = 10;
  localparam int COL_W   = COORD_W + 1;
  localparam int PAGE_W  = COORD_W - 2;
  localparam int X_BITS  = $clog2(SCREEN_WIDTH);
  localparam int SUM_RAW = X_BITS + $clog2(PAGES + 2);
  localparam int SUM_W   = (SUM_RAW > ADDR_W) ? SUM_RAW : ADDR_W;

  localparam int GLYPH_COLS   = 6;
  localparam int CELL_COLS    = 8;
  localparam int GCOL_W       = $clog2(GLYPH_COLS);
  localparam int CCOL_W       = $clog2(CELL_COLS);
  localparam int STEP_W       = CCOL_W + 1;
  localparam int FONT_ENTRIES = 96;
  localparam int FONT_IDX_W   = $clog2(FONT_ENTRIES);
  localparam int FONT_W       = GLYPH_COLS * DATA_W;

  localparam logic [7:0] CODE_LOW      = 8'h20;
  localparam logic [7:0] CODE_HIGH     = 8'h7F;
  localparam logic [7:0] CODE_FALLBACK = 8'h3F;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_GLYPH = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    COLOR_CLEAR  = 2'd0,
    COLOR_SET    = 2'd1,
    COLOR_INVERT = 2'd2,
    COLOR_KEEP   = 2'd3
  } color_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_GLYPH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              rd_req;
    logic              issue;
    logic              glyph;
    logic [STEP_W-1:0] step;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
  } ctrl_cmd_t;

  // one entry per character, leftmost column in the top byte
  localparam logic [FONT_W-1:0] FONT_ROM [FONT_ENTRIES] = '{
    48'h00_00_00_00_00_00, 48'h00_00_00_2f_00_00,
    48'h00_00_07_00_07_00, 48'h00_14_7f_14_7f_14,
    48'h00_24_2a_7f_2a_12, 48'h00_23_13_08_64_62,
    48'h00_36_49_55_22_50, 48'h00_00_05_03_00_00,
    48'h00_00_1c_22_41_00, 48'h00_00_41_22_1c_00,
    48'h00_14_08_3E_08_14, 48'h00_08_08_3E_08_08,
    48'h00_00_00_A0_60_00, 48'h00_08_08_08_08_08,
    48'h00_00_60_60_00_00, 48'h00_20_10_08_04_02,
    48'h00_3E_51_49_45_3E, 48'h00_00_42_7F_40_00,
    48'h00_42_61_51_49_46, 48'h00_21_41_45_4B_31,
    48'h00_18_14_12_7F_10, 48'h00_27_45_45_45_39,
    48'h00_3C_4A_49_49_30, 48'h00_01_71_09_05_03,
    48'h00_36_49_49_49_36, 48'h00_06_49_49_29_1E,
    48'h00_00_36_36_00_00, 48'h00_00_56_36_00_00,
    48'h00_08_14_22_41_00, 48'h00_14_14_14_14_14,
    48'h00_00_41_22_14_08, 48'h00_02_01_51_09_06,
    48'h00_32_49_59_51_3E, 48'h00_7C_12_11_12_7C,
    48'h00_7F_49_49_49_36, 48'h00_3E_41_41_41_22,
    48'h00_7F_41_41_22_1C, 48'h00_7F_49_49_49_41,
    48'h00_7F_09_09_09_01, 48'h00_3E_41_49_49_7A,
    48'h00_7F_08_08_08_7F, 48'h00_00_41_7F_41_00,
    48'h00_20_40_41_3F_01, 48'h00_7F_08_14_22_41,
    48'h00_7F_40_40_40_40, 48'h00_7F_02_0C_02_7F,
    48'h00_7F_04_08_10_7F, 48'h00_3E_41_41_41_3E,
    48'h00_7F_09_09_09_06, 48'h00_3E_41_51_21_5E,
    48'h00_7F_09_19_29_46, 48'h00_46_49_49_49_31,
    48'h00_01_01_7F_01_01, 48'h00_3F_40_40_40_3F,
    48'h00_1F_20_40_20_1F, 48'h00_3F_40_38_40_3F,
    48'h00_63_14_08_14_63, 48'h00_07_08_70_08_07,
    48'h00_61_51_49_45_43, 48'h00_00_7F_41_41_00,
    48'h00_55_2A_55_2A_55, 48'h00_00_41_41_7F_00,
    48'h00_04_02_01_02_04, 48'h00_40_40_40_40_40,
    48'h00_00_01_02_04_00, 48'h00_20_54_54_54_78,
    48'h00_7F_48_44_44_38, 48'h00_38_44_44_44_20,
    48'h00_38_44_44_48_7F, 48'h00_38_54_54_54_18,
    48'h00_08_7E_09_01_02, 48'h00_18_A4_A4_A4_7C,
    48'h00_7F_08_04_04_78, 48'h00_00_44_7D_40_00,
    48'h00_40_80_84_7D_00, 48'h00_7F_10_28_44_00,
    48'h00_00_41_7F_40_00, 48'h00_7C_04_18_04_78,
    48'h00_7C_08_04_04_78, 48'h00_38_44_44_44_38,
    48'h00_FC_24_24_24_18, 48'h00_18_24_24_18_FC,
    48'h00_7C_08_04_04_08, 48'h00_48_54_54_54_20,
    48'h00_04_3F_44_40_20, 48'h00_3C_40_40_20_7C,
    48'h00_1C_20_40_20_1C, 48'h00_3C_40_30_40_3C,
    48'h00_44_28_10_28_44, 48'h00_1C_A0_A0_A0_7C,
    48'h00_44_64_54_4C_44, 48'h00_00_08_77_00_00,
    48'h00_00_00_7F_00_00, 48'h00_00_77_08_00_00,
    48'h00_10_08_10_08_00, 48'h14_14_14_14_14_14
  };

endpackage

FILE: src/mono_framebuffer_plotter.sv
// mono_framebuffer_plotter: column-ordered 1bpp framebuffer with pixel, 6x8 glyph,
// byte read and clear requests. Depends on mfb_pkg, mfb_ctrl, mfb_datapath.
// Per request: read data is strobed the next cycle; pixel is one read-modify-write
// step; glyph is 16 pipelined read-modify-write steps, one byte per cycle through the
// store's single write port; clear writes one byte a cycle. Reset runs a clearing
// pass with busy high.

module mono_framebuffer_plotter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic signed [9:0] in_pos_x,
  input  logic signed [9:0] in_pos_y,
  input  logic [1:0]        in_pixel_color,
  input  logic [7:0]        in_char_code,
  input  logic              in_reversed,
  input  logic [9:0]        in_read_address,
  output logic              out_valid,
  output logic [7:0]        out_read_data
);

  import mfb_pkg::*;

  ctrl_cmd_t cmd;

  mfb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .busy  (busy),
    .cmd   (cmd)
  );

  mfb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pixel_color  (in_pixel_color),
    .in_char_code    (in_char_code),
    .in_reversed     (in_reversed),
    .in_read_address (in_read_address),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data)
  );

  a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_mode == MODE_READ))
    else $error("read strobe without a read request");

  a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode != MODE_READ) |=> busy)
    else $error("store request accepted without going busy");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_we && (cmd.issue || cmd.rd_req)))
    else $error("clearing sweep overlaps a draw or read");

endmodule

FILE: src/mfb_ram.sv
// mfb_ram: generic simple dual-port RAM, one write and one registered read
// port, read-first on a same-address collision. No dependencies.

module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mfb_ctrl.sv
// mfb_ctrl: request sequencer of the framebuffer plotter: clearing sweep,
// pixel and glyph step issue, read launch. Depends on mfb_pkg.

module mfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         mode,
  output logic               busy,
  output mfb_pkg::ctrl_cmd_t cmd
);

  import mfb_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    busy         = (state_r != ST_IDLE);
    cmd          = '0;
    cmd.step     = cnt_r[STEP_W-1:0];
    cmd.clr_addr = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        cnt_nxt    = ADDR_W'(cnt_r + 1'b1);
        if (cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          unique case (mode_t'(mode))
            MODE_PIXEL: state_nxt = ST_PIXEL;
            MODE_GLYPH: state_nxt = ST_GLYPH;
            MODE_READ:  cmd.rd_req = 1'b1;
            MODE_CLEAR: state_nxt = ST_CLEAR;
          endcase
        end
      end
      ST_PIXEL: begin
        cmd.issue = 1'b1;
        state_nxt = ST_DRAIN;
      end
      ST_GLYPH: begin
        cmd.issue = 1'b1;
        cmd.glyph = 1'b1;
        cnt_nxt   = ADDR_W'(cnt_r + 1'b1);
        if (cnt_r[STEP_W-1:0] == '1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/mfb_datapath.sv
// mfb_datapath: request registers, byte/mask generation, two-stage
// read-modify-write with forwarding, and the framebuffer store.
// Depends on mfb_pkg and mfb_ram.

module mfb_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mfb_pkg::ctrl_cmd_t          cmd,
  input  logic signed [9:0]           in_pos_x,
  input  logic signed [9:0]           in_pos_y,
  input  logic [1:0]                  in_pixel_color,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_reversed,
  input  logic [9:0]                  in_read_address,
  output logic                        out_valid,
  output logic [7:0]                  out_read_data
);

  import mfb_pkg::*;

  // request registers
  logic [COORD_W-1:0] x_r, y_r;
  color_t             color_r;
  logic [DATA_W-1:0]  glyph_r [GLYPH_COLS];

  logic [FONT_IDX_W-1:0] font_idx;
  logic [FONT_W-1:0]     font_bits;

  always_comb begin
    if (in_char_code >= CODE_LOW && in_char_code <= CODE_HIGH) begin
      font_idx = FONT_IDX_W'(in_char_code - CODE_LOW);
    end else begin
      font_idx = FONT_IDX_W'(CODE_FALLBACK - CODE_LOW);
    end
    font_bits = FONT_ROM[font_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      color_r <= color_t'(in_pixel_color);
      for (int c = 0; c < GLYPH_COLS; c++) begin
        glyph_r[c] <= font_bits[(GLYPH_COLS - 1 - c) * DATA_W +: DATA_W] ^ {DATA_W{in_reversed}};
      end
    end
  end

  // stage 1: byte address, mask and value of one step
  logic [CCOL_W-1:0]  col;
  logic [GCOL_W-1:0]  col_sel;
  logic               half;
  logic [COL_W-1:0]   xc;
  logic               col_ok;
  logic [PAGE_W-1:0]  pg;
  logic [2:0]         sh;
  logic [DATA_W-1:0]  src_bits;
  logic [2*DATA_W-1:0] wide, gm_wide;
  logic [DATA_W-1:0]  row_ok;
  logic [COL_W-1:0]   row;
  logic [SUM_W-1:0]   addr_sum;
  logic [ADDR_W-1:0]  s1_addr;
  logic [DATA_W-1:0]  s1_mask, s1_val;
  logic               s1_xor, keep;

  always_comb begin
    col     = cmd.glyph ? cmd.step[STEP_W-1:1] : '0;
    half    = cmd.glyph ? cmd.step[0] : 1'b0;
    col_sel = (col < CCOL_W'(GLYPH_COLS)) ? GCOL_W'(col) : '0;
    xc      = {x_r[COORD_W-1], x_r} + {{(COL_W - CCOL_W){1'b0}}, col};
    col_ok  = !xc[COL_W-1] && (xc < COL_W'(SCREEN_WIDTH));
    pg      = {y_r[COORD_W-1], y_r[COORD_W-1:3]} + {{(PAGE_W - 1){1'b0}}, half};
    sh      = y_r[2:0];
    row     = '0;
    for (int n = 0; n < DATA_W; n++) begin
      row       = {pg, 3'(n)};
      row_ok[n] = !pg[PAGE_W-1] && (row < COL_W'(SCREEN_HEIGHT));
    end
    if (cmd.glyph) begin
      src_bits = (col < CCOL_W'(GLYPH_COLS)) ? glyph_r[col_sel] : '0;
      gm_wide  = {{DATA_W{1'b0}}, {DATA_W{1'b1}}} << sh;
    end else begin
      src_bits = (color_r == COLOR_SET) ? {DATA_W{1'b1}} : '0;
      gm_wide  = {{(2 * DATA_W - 1){1'b0}}, 1'b1} << sh;
    end
    wide     = {{DATA_W{1'b0}}, src_bits} << sh;
    keep     = !cmd.glyph && (color_r == COLOR_KEEP);
    s1_xor   = !cmd.glyph && (color_r == COLOR_INVERT);
    s1_val   = half ? wide[2*DATA_W-1:DATA_W] : wide[DATA_W-1:0];
    s1_mask  = (half ? gm_wide[2*DATA_W-1:DATA_W] : gm_wide[DATA_W-1:0])
               & row_ok & {DATA_W{col_ok && !keep}};
    addr_sum = SUM_W'(xc[X_BITS-1:0]) * SUM_W'(PAGES) + SUM_W'(pg[PAGE_W-2:0]);
    s1_addr  = addr_sum[ADDR_W-1:0];
  end

  // stage 2: merge and write back
  logic              s2_vld_r, fwd_r, rd_vld_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [DATA_W-1:0] s2_mask_r, s2_val_r, fwd_data_r;
  logic              s2_xor_r;
  logic [DATA_W-1:0] ram_rdata, old_byte, new_byte;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata;

  always_comb begin
    old_byte = fwd_r ? fwd_data_r : ram_rdata;
    if (s2_xor_r) begin
      new_byte = old_byte ^ s2_mask_r;
    end else begin
      new_byte = (old_byte & ~s2_mask_r) | (s2_val_r & s2_mask_r);
    end
    ram_we    = cmd.clr_we || s2_vld_r;
    ram_waddr = cmd.clr_we ? cmd.clr_addr : s2_addr_r;
    ram_wdata = cmd.clr_we ? '0 : new_byte;
    ram_raddr = cmd.rd_req ? in_read_address : s1_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= cmd.issue && (s1_mask != '0);
      fwd_r    <= cmd.issue && s2_vld_r && (s2_addr_r == s1_addr);
      rd_vld_r <= cmd.rd_req;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r  <= s1_addr;
    s2_mask_r  <= s1_mask;
    s2_val_r   <= s1_val;
    s2_xor_r   <= s1_xor;
    fwd_data_r <= new_byte;
  end

  mfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = rd_vld_r;
  assign out_read_data = ram_rdata;

endmodule

FILE: test/mfb_checker.sv
// mfb_checker: watches the request and result channels of the framebuffer
// plotter, keeps its own copy of the frame store and checks every read byte.
// Depends on mfb_pkg for mode, color and screen constants.
`timescale 1ns / 100ps

module mfb_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_mode,
  input  logic signed [9:0] in_pos_x,
  input  logic signed [9:0] in_pos_y,
  input  logic [1:0]        in_pixel_color,
  input  logic [7:0]        in_char_code,
  input  logic              in_reversed,
  input  logic [9:0]        in_read_address,
  input  logic              out_valid,
  input  logic [7:0]        out_read_data,
  output int                fail_count,
  output int                pending
);

  import mfb_pkg::*;

  typedef struct {
    logic [9:0] addr;
    logic [7:0] data;
  } read_byte_t;

  // leftmost glyph column in the top byte
  localparam logic [47:0] GLYPHS [96] = '{
    48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
    48'h00242a7f2a12, 48'h002313086462, 48'h003649552250, 48'h000005030000,
    48'h00001c224100, 48'h000041221c00, 48'h0014083E0814, 48'h0008083E0808,
    48'h000000A06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
    48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h00324959513E, 48'h007C1211127C, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
    48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
    48'h00552A552A55, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
    48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
    48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h0018A4A4A47C,
    48'h007F08040478, 48'h0000447D4000, 48'h004080847D00, 48'h007F10284400,
    48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
    48'h00FC24242418, 48'h0018242418FC, 48'h007C08040408, 48'h004854545420,
    48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
    48'h004428102844, 48'h001CA0A0A07C, 48'h004464544C44, 48'h000008770000,
    48'h0000007F0000, 48'h000077080000, 48'h001008100800, 48'h141414141414
  };

  logic [7:0] frame_model [1024];
  read_byte_t read_queue [$];

  function automatic void plot_pixel(int x, int y, color_t c);
    logic [9:0] a;
    logic [7:0] m;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
    a = 10'(x * PAGES + y / 8);
    m = 8'(1 << (y % 8));
    unique case (c)
      COLOR_CLEAR:  frame_model[a] = frame_model[a] & ~m;
      COLOR_SET:    frame_model[a] = frame_model[a] | m;
      COLOR_INVERT: frame_model[a] = frame_model[a] ^ m;
      default: ;
    endcase
  endfunction

  function automatic void render_glyph(int x, int y, logic [7:0] code, logic rev);
    logic [7:0] k;
    logic [47:0] g;
    logic [7:0] bits;
    k = (code < CODE_LOW || code > CODE_HIGH) ? CODE_FALLBACK : code;
    g = GLYPHS[k - CODE_LOW];
    for (int col = 0; col < 6; col++) begin
      bits = g[47 - 8 * col -: 8];
      if (rev) bits = ~bits;
      for (int row = 0; row < 8; row++)
        plot_pixel(x + col, y + row, bits[row] ? COLOR_SET : COLOR_CLEAR);
    end
    for (int row = 0; row < 8; row++)
      for (int col = 6; col < 8; col++)
        plot_pixel(x + col, y + row, COLOR_CLEAR);
  endfunction

  always @(posedge clk) begin
    read_byte_t want;
    if (!rst_n) begin
      foreach (frame_model[i]) frame_model[i] = '0;
      read_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (read_queue.size() == 0) begin
          $display("%0t: read_data %02h with no read pending", $time, out_read_data);
          fail_count++;
        end else begin
          want = read_queue.pop_front();
          if (out_read_data !== want.data) begin
            $display("%0t: read_data at %0d: expected %02h, actual %02h",
                     $time, want.addr, want.data, out_read_data);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        unique case (mode_t'(in_mode))
          MODE_PIXEL: plot_pixel(int'(in_pos_x), int'(in_pos_y), color_t'(in_pixel_color));
          MODE_GLYPH: render_glyph(int'(in_pos_x), int'(in_pos_y), in_char_code, in_reversed);
          MODE_READ:  read_queue.push_back('{in_read_address, frame_model[in_read_address]});
          default:    foreach (frame_model[i]) frame_model[i] = '0;
        endcase
      end
    end
    pending = read_queue.size();
  end

endmodule

FILE: test/mono_framebuffer_plotter_tb.sv
// mono_framebuffer_plotter_tb: drives pixel, glyph, read and clear requests
// in random bursts into the plotter and reports the verdict.
// Depends on mfb_pkg, mono_framebuffer_plotter and mfb_checker.
`timescale 1ns / 100ps

module mono_framebuffer_plotter_tb;

  import mfb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_mode;
  logic signed [9:0] in_pos_x;
  logic signed [9:0] in_pos_y;
  logic [1:0]        in_pixel_color;
  logic [7:0]        in_char_code;
  logic              in_reversed;
  logic [9:0]        in_read_address;
  logic              out_valid;
  logic [7:0]        out_read_data;
  int                mismatches;
  int                reads_pending;
  int                cycle_count = 0;
  int                burst_left = 0;

  mono_framebuffer_plotter u_top (
    .clk, .rst_n, .start, .busy, .in_mode, .in_pos_x, .in_pos_y,
    .in_pixel_color, .in_char_code, .in_reversed, .in_read_address,
    .out_valid, .out_read_data
  );

  mfb_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_mode, .in_pos_x, .in_pos_y,
    .in_pixel_color, .in_char_code, .in_reversed, .in_read_address,
    .out_valid, .out_read_data, .fail_count(mismatches), .pending(reads_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(mode_t m, int x, int y, int color, int code, int rev, int addr);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_mode         = m;
    in_pos_x        = 10'(x);
    in_pos_y        = 10'(y);
    in_pixel_color  = 2'(color);
    in_char_code    = 8'(code);
    in_reversed     = 1'(rev);
    in_read_address = 10'(addr);
    start           = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  initial begin
    int pick;
    int x;
    int y;
    int code;
    int lx;
    int ly;
    int addr;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_PIXEL;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pixel_color = COLOR_CLEAR;
    in_char_code = '0;
    in_reversed = 1'b0;
    in_read_address = '0;
    lx = 0;
    ly = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    send_request(MODE_PIXEL, 0, 0, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, 127, 63, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    send_request(MODE_PIXEL, 127, 63, COLOR_INVERT, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, 0, 0, COLOR_KEEP, $urandom, $urandom, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 1023);
    send_request(MODE_PIXEL, 0, 0, COLOR_CLEAR, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, -1, 0, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, 128, 0, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, 0, -1, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, 0, 64, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, -512, -512, COLOR_INVERT, $urandom, $urandom, $urandom);
    send_request(MODE_PIXEL, 511, 511, COLOR_SET, $urandom, $urandom, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    send_request(MODE_GLYPH, 0, 0, $urandom, 8'h41, 0, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 2 * PAGES);
    send_request(MODE_GLYPH, 122, 60, $urandom, 8'h00, 1, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 1023);
    send_request(MODE_GLYPH, -3, -4, $urandom, 8'hFF, 0, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    send_request(MODE_GLYPH, 40, 20, $urandom, CODE_HIGH, 1, $urandom);
    send_request(MODE_GLYPH, 40, 21, $urandom, CODE_LOW, 0, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 46 * PAGES + 2);
    send_request(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 40 * PAGES + 3);

    for (int n = 0; n < 630; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 6) == 0) begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
      end else begin
        x = int'($urandom_range(0, SCREEN_WIDTH + 15)) - 8;
        y = int'($urandom_range(0, SCREEN_HEIGHT + 15)) - 8;
      end
      code = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(CODE_LOW, CODE_HIGH);
      if ($urandom_range(0, 2) == 0)
        addr = $urandom_range(0, 1023);
      else
        addr = ((lx + int'($urandom_range(0, 7))) & (SCREEN_WIDTH - 1)) * PAGES
             + ((ly + int'($urandom_range(0, 7))) & (SCREEN_HEIGHT - 1)) / 8;
      if (pick < 30) begin
        send_request(MODE_PIXEL, x, y, $urandom_range(0, 3), $urandom, $urandom, $urandom);
        lx = x;
        ly = y;
      end else if (pick < 55) begin
        send_request(MODE_GLYPH, x, y, $urandom, code, $urandom, $urandom);
        lx = x;
        ly = y;
      end else if (pick < 98) begin
        send_request(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, addr);
      end else begin
        send_request(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end

    start = 1'b0;
    while (reads_pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && reads_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
